FILE: rtl/wc3_pkg.sv
package wc3_pkg;

	localparam int SAMPLE_BITS = 8;
	localparam int DIV_BITS    = 9;
	localparam int QUO_BITS    = 8;
	localparam int IDX_BITS    = 3;
	localparam int TAPS        = 3;

	localparam logic [QUO_BITS-1:0] OUT_MAX  = 8'd255;
	localparam logic [QUO_BITS-1:0] OUT_ZERO = 8'd0;

	localparam logic [IDX_BITS-1:0] REG_ROW_TOP    = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_ROW_MIDDLE = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_ROW_BOTTOM = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_DIVISOR    = 3'd3;

	localparam logic signed [DIV_BITS-1:0] DIV_RESET = 9'sd3;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [DIV_BITS-1:0]    dmag_t;
	typedef logic [QUO_BITS-1:0]    quo_t;

	typedef struct packed {
		logic sat;
		logic zero;
	} flags_t;

endpackage

FILE: rtl/window_convolution_3x3_clamped_core.sv
// 3x3 window convolution with normalization and clamping. One window of nine
// 8-bit samples is taken per clock cycle and one clamped 8-bit result leaves
// per cycle while the output is not stalled; each result passes through the
// registers of the three row lanes, the merge of the row sums, the restoring
// divider (one quotient bit per stage) and the output register. A stalled
// output backs up the pipeline one stage at a time, so windows are still
// taken while empty stages remain. The kernel rows and the divisor are
// written through cfg_we/cfg_index/cfg_data and must only change while no
// window is in flight; a divisor of zero divides by one.
module window_convolution_3x3_clamped_core #(
	parameter int COEFF_BITS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [wc3_pkg::IDX_BITS-1:0] cfg_index,
	input  logic [((3*COEFF_BITS > wc3_pkg::DIV_BITS) ? 3*COEFF_BITS : wc3_pkg::DIV_BITS)-1:0]
		cfg_data,
	input  logic                   win_valid,
	output logic                   win_stall,
	input  wc3_pkg::sample_t       top_left,
	input  wc3_pkg::sample_t       top_middle,
	input  wc3_pkg::sample_t       top_right,
	input  wc3_pkg::sample_t       middle_left,
	input  wc3_pkg::sample_t       center_sample,
	input  wc3_pkg::sample_t       middle_right,
	input  wc3_pkg::sample_t       bottom_left,
	input  wc3_pkg::sample_t       bottom_middle,
	input  wc3_pkg::sample_t       bottom_right,
	output logic                   res_valid,
	input  logic                   res_stall,
	output wc3_pkg::sample_t       result_sample
);
	import wc3_pkg::*;

	localparam int ROW_BITS = 3 * COEFF_BITS;
	localparam int ROW_W    = SAMPLE_BITS + COEFF_BITS + 2;
	localparam int MAG_W    = SAMPLE_BITS + COEFF_BITS + 4;
	localparam int NST      = QUO_BITS + 3;

	localparam logic [ROW_BITS-1:0] ROW_TOP_RESET    = ROW_BITS'(1);
	localparam logic [ROW_BITS-1:0] ROW_MIDDLE_RESET = ROW_BITS'(1) << COEFF_BITS;
	localparam logic [ROW_BITS-1:0] ROW_BOTTOM_RESET = ROW_BITS'(1) << (2 * COEFF_BITS);

	logic [ROW_BITS-1:0] row_top_q, row_middle_q, row_bottom_q;
	logic [DIV_BITS-1:0] divisor_q;

	logic [NST-1:0] v_q;
	logic [NST:0]   rdy;

	sample_t                 win [3][3];
	logic signed [ROW_W-1:0] row_s1 [3];
	logic [MAG_W-1:0]        rem_s2;
	flags_t                  flags_s2;
	logic [MAG_W-1:0]        div_rem_s [QUO_BITS+1];
	quo_t                    div_quo_s [QUO_BITS+1];
	flags_t                  div_flags_s [QUO_BITS+1];
	sample_t                 out_s11;

	dmag_t dmag;
	logic  div_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_top_q    <= ROW_TOP_RESET;
			row_middle_q <= ROW_MIDDLE_RESET;
			row_bottom_q <= ROW_BOTTOM_RESET;
			divisor_q    <= DIV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW_TOP:    row_top_q    <= cfg_data[ROW_BITS-1:0];
				REG_ROW_MIDDLE: row_middle_q <= cfg_data[ROW_BITS-1:0];
				REG_ROW_BOTTOM: row_bottom_q <= cfg_data[ROW_BITS-1:0];
				REG_DIVISOR:    divisor_q    <= cfg_data[DIV_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		div_neg = divisor_q[DIV_BITS-1];
		if (divisor_q == '0) begin
			dmag = DIV_BITS'(1);
		end else if (div_neg) begin
			dmag = DIV_BITS'(-divisor_q);
		end else begin
			dmag = divisor_q;
		end
	end

	// advance a stage when it is empty or the one after it advances
	always_comb begin
		rdy[NST] = !res_stall;
		for (int k = NST - 1; k >= 0; k--) begin
			rdy[k] = !v_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= win_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (rdy[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	assign win_stall = !rdy[0];
	assign res_valid = v_q[NST-1];

	assign win[0][0] = top_left;
	assign win[0][1] = top_middle;
	assign win[0][2] = top_right;
	assign win[1][0] = middle_left;
	assign win[1][1] = center_sample;
	assign win[1][2] = middle_right;
	assign win[2][0] = bottom_left;
	assign win[2][1] = bottom_middle;
	assign win[2][2] = bottom_right;

	wc3_row_lane #(.COEFF_BITS(COEFF_BITS)) u_lane_top (
		.clk(clk), .en(rdy[0]), .samples(win[0]), .row(row_top_q), .row_sum_q(row_s1[0])
	);
	wc3_row_lane #(.COEFF_BITS(COEFF_BITS)) u_lane_middle (
		.clk(clk), .en(rdy[0]), .samples(win[1]), .row(row_middle_q), .row_sum_q(row_s1[1])
	);
	wc3_row_lane #(.COEFF_BITS(COEFF_BITS)) u_lane_bottom (
		.clk(clk), .en(rdy[0]), .samples(win[2]), .row(row_bottom_q), .row_sum_q(row_s1[2])
	);

	wc3_merge #(.COEFF_BITS(COEFF_BITS)) u_merge (
		.clk(clk), .en(rdy[1]), .row_sum(row_s1), .dmag(dmag), .div_neg(div_neg),
		.rem_q(rem_s2), .flags_q(flags_s2)
	);

	assign div_rem_s[0]   = rem_s2;
	assign div_quo_s[0]   = OUT_ZERO;
	assign div_flags_s[0] = flags_s2;

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		wc3_div_step #(.MAG_W(MAG_W), .SHIFT(QUO_BITS - 1 - i)) u_step (
			.clk(clk), .en(rdy[i+2]), .dmag(dmag),
			.rem_i(div_rem_s[i]), .quo_i(div_quo_s[i]), .flags_i(div_flags_s[i]),
			.rem_q(div_rem_s[i+1]), .quo_q(div_quo_s[i+1]), .flags_q(div_flags_s[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (rdy[NST-1]) begin
			if (div_flags_s[QUO_BITS].sat) begin
				out_s11 <= OUT_MAX;
			end else if (div_flags_s[QUO_BITS].zero) begin
				out_s11 <= OUT_ZERO;
			end else begin
				out_s11 <= div_quo_s[QUO_BITS];
			end
		end
	end

	assign result_sample = out_s11;

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		win_stall |-> &v_q)
		else $error("window stalled with an empty stage");

	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		win_stall |-> res_stall)
		else $error("window stalled while result side takes words");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && !v_q[NST-2]) |=> !res_valid)
		else $error("result word repeated after drain");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[NST-2] && !div_flags_s[QUO_BITS].sat && !div_flags_s[QUO_BITS].zero)
			|-> (div_rem_s[QUO_BITS] < MAG_W'(dmag)))
		else $error("divider remainder not below divisor");

endmodule

FILE: rtl/wc3_row_lane.sv
module wc3_row_lane #(
	parameter int COEFF_BITS = 5
) (
	input  logic                                              clk,
	input  logic                                              en,
	input  wc3_pkg::sample_t                                  samples [3],
	input  logic [3*COEFF_BITS-1:0]                           row,
	output logic signed [wc3_pkg::SAMPLE_BITS+COEFF_BITS+1:0] row_sum_q
);
	import wc3_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEFF_BITS + 1;
	localparam int ROW_W  = SAMPLE_BITS + COEFF_BITS + 2;

	logic signed [PROD_W-1:0] prod [TAPS];
	logic signed [ROW_W-1:0]  sum;

	always_comb begin
		for (int k = 0; k < TAPS; k++) begin
			prod[k] = PROD_W'($signed({1'b0, samples[k]}))
				* PROD_W'($signed(row[k*COEFF_BITS +: COEFF_BITS]));
		end
		sum = ROW_W'(prod[0]) + ROW_W'(prod[1]) + ROW_W'(prod[2]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_sum_q <= sum;
		end
	end

endmodule

FILE: rtl/wc3_merge.sv
module wc3_merge #(
	parameter int COEFF_BITS = 5
) (
	input  logic                                              clk,
	input  logic                                              en,
	input  logic signed [wc3_pkg::SAMPLE_BITS+COEFF_BITS+1:0] row_sum [3],
	input  wc3_pkg::dmag_t                                    dmag,
	input  logic                                              div_neg,
	output logic [wc3_pkg::SAMPLE_BITS+COEFF_BITS+3:0]        rem_q,
	output wc3_pkg::flags_t                                   flags_q
);
	import wc3_pkg::*;

	localparam int ACC_W = SAMPLE_BITS + COEFF_BITS + 4;
	localparam int CMP_W = ACC_W + DIV_BITS;

	logic signed [ACC_W-1:0] acc;
	logic [ACC_W-1:0]        mag;
	logic [CMP_W-1:0]        limit;
	flags_t                  flags;

	always_comb begin
		acc = ACC_W'(row_sum[0]) + ACC_W'(row_sum[1]) + ACC_W'(row_sum[2]);
		mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
		limit = CMP_W'(dmag) << QUO_BITS;
		flags.zero = acc[ACC_W-1] != div_neg;
		flags.sat  = !flags.zero && (CMP_W'(mag) >= limit);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q   <= mag;
			flags_q <= flags;
		end
	end

endmodule

FILE: rtl/wc3_div_step.sv
module wc3_div_step #(
	parameter int MAG_W = 17,
	parameter int SHIFT = 7
) (
	input  logic             clk,
	input  logic             en,
	input  wc3_pkg::dmag_t   dmag,
	input  logic [MAG_W-1:0] rem_i,
	input  wc3_pkg::quo_t    quo_i,
	input  wc3_pkg::flags_t  flags_i,
	output logic [MAG_W-1:0] rem_q,
	output wc3_pkg::quo_t    quo_q,
	output wc3_pkg::flags_t  flags_q
);
	import wc3_pkg::*;

	localparam int CMP_W = MAG_W + DIV_BITS;

	logic [CMP_W-1:0] trial;
	logic [CMP_W-1:0] diff;
	logic             ge;
	quo_t             quo;

	always_comb begin
		trial = CMP_W'(dmag) << SHIFT;
		diff  = CMP_W'(rem_i) - trial;
		ge    = CMP_W'(rem_i) >= trial;
		quo   = quo_i;
		quo[SHIFT] = ge;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q   <= ge ? diff[MAG_W-1:0] : rem_i;
			quo_q   <= quo;
			flags_q <= flags_i;
		end
	end

endmodule

FILE: tb/convolution_checker.sv
module convolution_checker #(
	parameter int COEFF_BITS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wc3_pkg::IDX_BITS-1:0]   cfg_index,
	input  logic [((3*COEFF_BITS > wc3_pkg::DIV_BITS) ? 3*COEFF_BITS : wc3_pkg::DIV_BITS)-1:0]
		cfg_data,
	input  logic                           win_valid,
	input  logic                           win_stall,
	input  wc3_pkg::sample_t               top_left,
	input  wc3_pkg::sample_t               top_middle,
	input  wc3_pkg::sample_t               top_right,
	input  wc3_pkg::sample_t               middle_left,
	input  wc3_pkg::sample_t               center_sample,
	input  wc3_pkg::sample_t               middle_right,
	input  wc3_pkg::sample_t               bottom_left,
	input  wc3_pkg::sample_t               bottom_middle,
	input  wc3_pkg::sample_t               bottom_right,
	input  logic                           res_valid,
	input  logic                           res_stall,
	input  wc3_pkg::sample_t               result_sample,
	output int                             pending,
	output int                             failures
);

	timeunit 1ns;
	timeprecision 1ps;

	import wc3_pkg::*;

	localparam int ROW_BITS = 3 * COEFF_BITS;

	logic [ROW_BITS-1:0]        kernel_rows [3];
	logic signed [DIV_BITS-1:0] divisor;
	quo_t                       expected_samples [$];

	function automatic quo_t clamped_convolution(input sample_t win [9]);
		int acc;
		int divisor_val;
		int quotient;
		logic signed [COEFF_BITS-1:0] coeff;
		acc = 0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coeff = kernel_rows[r][c*COEFF_BITS +: COEFF_BITS];
				acc += int'(win[3*r + c]) * int'(coeff);
			end
		end
		divisor_val = int'(divisor);
		if (divisor_val == 0) begin
			divisor_val = 1;
		end
		quotient = acc / divisor_val;
		if (quotient > int'(OUT_MAX)) begin
			return OUT_MAX;
		end else if (quotient < 0) begin
			return OUT_ZERO;
		end
		return quo_t'(quotient);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sample_t win [9];
		quo_t    want;
		if (!arst_n) begin
			kernel_rows[0] <= ROW_BITS'(1);
			kernel_rows[1] <= ROW_BITS'(1) << COEFF_BITS;
			kernel_rows[2] <= ROW_BITS'(1) << (2 * COEFF_BITS);
			divisor        <= DIV_RESET;
			expected_samples.delete();
			pending        <= 0;
			failures       = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROW_TOP:    kernel_rows[0] <= cfg_data[ROW_BITS-1:0];
					REG_ROW_MIDDLE: kernel_rows[1] <= cfg_data[ROW_BITS-1:0];
					REG_ROW_BOTTOM: kernel_rows[2] <= cfg_data[ROW_BITS-1:0];
					REG_DIVISOR:    divisor        <= cfg_data[DIV_BITS-1:0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (expected_samples.size() == 0) begin
					$error("result_sample: expected none, got %0d", result_sample);
					failures++;
				end else begin
					want = expected_samples.pop_front();
					if (result_sample !== want) begin
						$error("result_sample: expected %0d, got %0d", want, result_sample);
						failures++;
					end
				end
			end
			if (win_valid && !win_stall) begin
				win = '{top_left, top_middle, top_right,
					middle_left, center_sample, middle_right,
					bottom_left, bottom_middle, bottom_right};
				expected_samples.push_back(clamped_convolution(win));
			end
			pending <= expected_samples.size();
		end
	end

endmodule

FILE: tb/testbench.sv
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import wc3_pkg::*;

	localparam int COEFF_BITS  = 5;
	localparam int ROW_BITS    = 3 * COEFF_BITS;
	localparam int CFG_BITS    = (ROW_BITS > DIV_BITS) ? ROW_BITS : DIV_BITS;
	localparam int COEFF_MAX   = 15;
	localparam int COEFF_MIN   = -16;
	localparam int HOLD_CYCLES = 60;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 250;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data  = '0;
	logic                win_valid = 1'b0;
	logic                win_stall;
	sample_t             top_left      = '0;
	sample_t             top_middle    = '0;
	sample_t             top_right     = '0;
	sample_t             middle_left   = '0;
	sample_t             center_sample = '0;
	sample_t             middle_right  = '0;
	sample_t             bottom_left   = '0;
	sample_t             bottom_middle = '0;
	sample_t             bottom_right  = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	sample_t             result_sample;

	int pending;
	int failures;
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_requests  = 0;
	int hold_served    = 0;
	int hold_left      = 0;

	window_convolution_3x3_clamped_core #(.COEFF_BITS(COEFF_BITS)) DUT (.*);

	convolution_checker #(.COEFF_BITS(COEFF_BITS)) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	always @(negedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			res_stall   <= 1'b1;
			hold_served <= hold_requests;
			hold_left   <= HOLD_CYCLES;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic logic [ROW_BITS-1:0] pack_row(input int left, mid, right);
		return {COEFF_BITS'(right), COEFF_BITS'(mid), COEFF_BITS'(left)};
	endfunction

	function automatic int rand_coeff();
		case ($urandom_range(3))
			0: return COEFF_MIN;
			1: return COEFF_MAX;
			default: return int'($urandom_range(31)) + COEFF_MIN;
		endcase
	endfunction

	function automatic sample_t rand_sample();
		if ($urandom_range(3) == 0) begin
			return $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return sample_t'($urandom);
	endfunction

	task automatic cfg_write(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_kernel(input int a0, a1, a2, b0, b1, b2, c0, c1, c2, input int divisor);
		cfg_write(REG_ROW_TOP,    CFG_BITS'(pack_row(a0, a1, a2)));
		cfg_write(REG_ROW_MIDDLE, CFG_BITS'(pack_row(b0, b1, b2)));
		cfg_write(REG_ROW_BOTTOM, CFG_BITS'(pack_row(c0, c1, c2)));
		cfg_write(REG_DIVISOR,    CFG_BITS'(divisor));
	endtask

	task automatic send_window(input sample_t w [9]);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			win_valid <= 1'b0;
			@(negedge clk);
		end
		win_valid     <= 1'b1;
		top_left      <= w[0];
		top_middle    <= w[1];
		top_right     <= w[2];
		middle_left   <= w[3];
		center_sample <= w[4];
		middle_right  <= w[5];
		bottom_left   <= w[6];
		bottom_middle <= w[7];
		bottom_right  <= w[8];
		do @(posedge clk); while (win_stall);
	endtask

	task automatic send_random();
		sample_t w [9];
		foreach (w[i]) w[i] = rand_sample();
		send_window(w);
	endtask

	// hold the sender until every outstanding word has been checked
	task automatic drain();
		@(negedge clk);
		win_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
			default: begin send_idle_pct = 10; recv_stall_pct = 10; end
		endcase
	endtask

	initial begin
		int k [9];
		int divisor;
		int sum;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset kernel: diagonal blur over three
		send_window('{9{8'h00}});
		send_window('{9{8'hFF}});
		send_window('{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF});
		send_window('{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'h02});
		drain();

		// largest coefficients, divisor zero after masking the upper bits
		set_kernel(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX,
			COEFF_MAX, COEFF_MAX, COEFF_MAX, 0);
		cfg_write(REG_DIVISOR, {{(CFG_BITS-DIV_BITS){1'b1}}, {DIV_BITS{1'b0}}});
		send_window('{9{8'hFF}});
		send_window('{9{8'h00}});
		send_window('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00});
		drain();

		// most negative coefficients over a negative divisor
		set_kernel(COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN, COEFF_MIN,
			COEFF_MIN, COEFF_MIN, COEFF_MIN, -144);
		send_window('{9{8'hFF}});
		send_window('{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
		send_window('{9{8'h00}});
		drain();
		cfg_write(REG_DIVISOR, CFG_BITS'(1));
		send_window('{9{8'hFF}});
		drain();

		set_kernel(COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX, COEFF_MAX,
			COEFF_MAX, COEFF_MAX, COEFF_MAX, 135);
		send_window('{9{8'hFF}});
		send_window('{9{8'h01}});
		drain();

		// mixed signs with negative divisors; writes to unused indexes change nothing
		set_kernel(COEFF_MIN, COEFF_MAX, 1, 0, -1, 7, 3, -8, COEFF_MAX, -1);
		for (int i = REG_DIVISOR + 1; i < 2**IDX_BITS; i++) begin
			cfg_write(IDX_BITS'(i), CFG_BITS'($urandom));
		end
		repeat (3) send_random();
		drain();
		cfg_write(REG_DIVISOR, CFG_BITS'(-7));
		repeat (3) send_random();
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			sum = 0;
			foreach (k[i]) begin
				k[i] = rand_coeff();
				sum += k[i];
			end
			case ($urandom_range(7))
				0: divisor = 0;
				1: divisor = int'($urandom_range(511)) - 256;
				2, 3: divisor = int'($urandom_range(279)) - 144;
				default: divisor = sum;
			endcase
			set_kernel(k[0], k[1], k[2], k[3], k[4], k[5], k[6], k[7], k[8], divisor);
			set_idling(phase % 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (phase == 0 && n == 50) begin
					hold_requests++;
				end
				if (phase == 1 && n == PHASE_ITEMS / 2) begin
					drain();
				end
				send_random();
			end
			drain();
		end

		set_idling(0);
		repeat (20) @(negedge clk);
		if (failures == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
